[rtl/core/double_ended_queue_assert.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_assert.svh
// Assertion macros used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// property checked only while out of reset
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH  = 16;
    localparam int DEQ_DATA_W = 32;
    localparam int DEQ_CNT_W  = $clog2(DEQ_DEPTH + 1);
    localparam int DEQ_OP_W   = 3;

    typedef logic signed [DEQ_DATA_W-1:0] t_word;

    localparam t_word DEQ_WORD_MIN = {1'b1, {(DEQ_DATA_W-1){1'b0}}};

    typedef enum logic [DEQ_OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef struct packed {
        logic [DEQ_OP_W-1:0] operation;
        t_word               value;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        t_word                popped_value;
        t_word                front_value;
        t_word                rear_value;
        logic [DEQ_CNT_W-1:0] element_count;
        logic                 is_empty;
    } t_out_item;

    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
        logic clear;
    } t_cell_cmd;

endpackage

[rtl/core/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue chain: a word and its occupied flag.
// Shifts toward the rear on push front, toward the front on pop front.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_word     i_value,
    input  logic      i_prev_occ,
    input  t_word     i_prev_data,
    input  logic      i_next_occ,
    input  t_word     i_next_data,
    output logic      o_occ,
    output t_word     o_data,
    output t_word     o_tail_data
);

    logic  r_occ;
    t_word r_data;
    logic  rear_slot;
    logic  is_tail;

    // first free cell after the last occupied one
    assign rear_slot = !r_occ && i_prev_occ;
    assign is_tail   = r_occ && !i_next_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_cmd.clear) begin
            r_occ <= 1'b0;
        end else if (i_cmd.push_front) begin
            r_occ <= i_prev_occ;
        end else if (i_cmd.push_rear) begin
            if (rear_slot) begin
                r_occ <= 1'b1;
            end
        end else if (i_cmd.pop_front) begin
            r_occ <= i_next_occ;
        end else if (i_cmd.pop_rear) begin
            if (is_tail) begin
                r_occ <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_front) begin
            r_data <= i_prev_data;
        end else if (i_cmd.push_rear && rear_slot) begin
            r_data <= i_value;
        end else if (i_cmd.pop_front) begin
            r_data <= i_next_data;
        end
    end

    assign o_occ       = r_occ;
    assign o_data      = r_data;
    assign o_tail_data = is_tail ? r_data : '0;

endmodule

[rtl/core/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Accepted item: the cell chain updates and the FSM enters scan, where both
// ends are read (rear through an OR over the cell tail taps) and the result
// is registered once the output is free; input stalls until then.
// Reset: synchronous, clears occupancy, count and valid; words unreset.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [DEQ_CNT_W-1:0] r_count;
    logic [DEQ_CNT_W-1:0] n_count;
    t_status              r_status;
    t_status              n_status;
    t_word                r_popped;
    t_word                n_popped;
    logic                 r_out_vld;
    t_out_item            r_out;
    t_out_item            n_out;

    logic [DEQ_DEPTH+1:0] occ_ext;
    t_word                data_ext [DEQ_DEPTH+2];
    t_word                tail_data [DEQ_DEPTH];
    t_word                rear_word;
    t_cell_cmd            cell_cmd;
    logic                 in_acc;
    logic                 out_free;
    logic                 full;
    logic                 empty;

    // chain ends: front neighbor always occupied, rear neighbor always free
    assign occ_ext[0]           = 1'b1;
    assign occ_ext[DEQ_DEPTH+1] = 1'b0;
    assign data_ext[0]          = i_in.value;
    assign data_ext[DEQ_DEPTH+1] = '0;

    for (genvar g = 0; g < DEQ_DEPTH; g++) begin : g_cell
        deq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cell_cmd),
            .i_value     (i_in.value),
            .i_prev_occ  (occ_ext[g]),
            .i_prev_data (data_ext[g]),
            .i_next_occ  (occ_ext[g+2]),
            .i_next_data (data_ext[g+2]),
            .o_occ       (occ_ext[g+1]),
            .o_data      (data_ext[g+1]),
            .o_tail_data (tail_data[g])
        );
    end

    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEQ_DEPTH; i++) begin
            rear_word = rear_word | tail_data[i];
        end
    end

    assign empty    = !occ_ext[1];
    assign full     = occ_ext[DEQ_DEPTH];
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        cell_cmd = '0;
        n_status = ST_OK;
        n_popped = '0;
        n_count  = r_count;
        case (i_in.operation)
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_OVER;
                end else begin
                    cell_cmd.push_front = 1'b1;
                    n_count = r_count + DEQ_CNT_W'(1);
                end
            end
            OP_PUSH_REAR: begin
                if (full) begin
                    n_status = ST_OVER;
                end else begin
                    cell_cmd.push_rear = 1'b1;
                    n_count = r_count + DEQ_CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_UNDER;
                end else begin
                    cell_cmd.pop_front = 1'b1;
                    n_popped = data_ext[1];
                    n_count = r_count - DEQ_CNT_W'(1);
                end
            end
            OP_POP_REAR: begin
                if (empty) begin
                    n_status = ST_UNDER;
                end else begin
                    cell_cmd.pop_rear = 1'b1;
                    n_popped = rear_word;
                    n_count = r_count - DEQ_CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                cell_cmd.clear = 1'b1;
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!in_acc) begin
            cell_cmd = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out.status        = r_status;
        n_out.popped_value  = r_popped;
        n_out.front_value   = empty ? DEQ_WORD_MIN : data_ext[1];
        n_out.rear_value    = empty ? DEQ_WORD_MIN : rear_word;
        n_out.element_count = r_count;
        n_out.is_empty      = empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_count <= n_count;
            end
            if ((r_state == S_SCAN) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
        if ((r_state == S_SCAN) && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

[rtl/core/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_port_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module deq_port_checker import deq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    `DEQ_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !o_out_valid, "out valid after reset")
    `DEQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled item changed")
    `DEQ_ASSERT(a_one_in_flight, i_clk, i_rst_n, in_acc |=> o_in_stall, "item accepted while busy")
    `DEQ_ASSERT(a_empty_ends, i_clk, i_rst_n, o_out_valid && o_out.is_empty |-> (o_out.element_count == '0) && (o_out.front_value == DEQ_WORD_MIN) && (o_out.rear_value == DEQ_WORD_MIN), "empty item inconsistent")
    `DEQ_ASSERT(a_count_range, i_clk, i_rst_n, o_out_valid |-> (o_out.element_count <= DEQ_CNT_W'(DEQ_DEPTH)) && (o_out.is_empty == (o_out.element_count == '0)), "count out of range")

endmodule

bind double_ended_queue deq_port_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
